[rtl/partial_hausdorff_distance_assert.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef PARTIAL_HAUSDORFF_DISTANCE_ASSERT_SVH
`define PARTIAL_HAUSDORFF_DISTANCE_ASSERT_SVH

// Same-cycle implication under reset.
`define PHD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under reset.
`define PHD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/phd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package phd_pkg;

   localparam int DIST_W = 25;
   localparam logic [DIST_W-1:0] DIST_MAX = 25'h1FF_FFFF;
   localparam logic [16:0] RANK_ONE = 17'd65536;
   localparam int DRAIN_CYCLES = 6;

   localparam logic [1:0] OP_LOAD_A  = 2'd0;
   localparam logic [1:0] OP_LOAD_B  = 2'd1;
   localparam logic [1:0] OP_COMPUTE = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic CSR_DIST_TYPE = 1'b0;
   localparam logic CSR_RANK_Q16  = 1'b1;

   localparam logic METRIC_L1 = 1'b0;
   localparam logic METRIC_L2 = 1'b1;

   typedef struct packed {
      logic [1:0]   op;
      logic signed [15:0] x;
      logic signed [15:0] y;
   } req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic insert;
      logic shift;
   } sort_ctl_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } pipe_tag_type;

endpackage
`default_nettype wire

[rtl/phd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module phd_cell
   import phd_pkg::*;
#(
   parameter int KW = 33
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sort_ctl_type ctl,
   input  wire logic [KW-1:0] ins_key,
   input  wire logic         left_le,
   input  wire logic [KW-1:0] left_key,
   input  wire logic         left_valid,
   input  wire logic [KW-1:0] right_key,
   input  wire logic         right_valid,
   output logic [KW-1:0]     key_o,
   output logic              valid_o,
   output logic              le_o
);

   logic [KW-1:0] key_ff, key_in;
   logic          valid_ff, valid_in;

   assign le_o    = valid_ff && (key_ff <= ins_key);
   assign key_o   = key_ff;
   assign valid_o = valid_ff;

   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         key_in   = right_key;
         valid_in = right_valid;
      end else if (ctl.insert && !le_o) begin
         // keep ascending order: take the new key or push the left one down
         if (left_le) begin
            key_in   = ins_key;
            valid_in = 1'b1;
         end else begin
            key_in   = left_key;
            valid_in = left_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

[rtl/phd_sorter.sv]
`timescale 1ns / 1ps
`default_nettype none
module phd_sorter
   import phd_pkg::*;
#(
   parameter int N  = 256,
   parameter int KW = 33
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire sort_ctl_type  ctl,
   input  wire logic [KW-1:0] ins_key,
   output logic [KW-1:0]      head_key
);

   logic [KW-1:0] key_w [N];
   logic          valid_w [N];
   logic          le_w [N];

   for (genvar c = 0; c < N; c++) begin : g_cell
      logic          l_le;
      logic [KW-1:0] l_key;
      logic          l_valid;
      logic [KW-1:0] r_key;
      logic          r_valid;

      if (c == 0) begin : g_first
         assign l_le    = 1'b1;
         assign l_key   = '0;
         assign l_valid = 1'b0;
      end else begin : g_mid
         assign l_le    = le_w[c-1];
         assign l_key   = key_w[c-1];
         assign l_valid = valid_w[c-1];
      end

      if (c == N-1) begin : g_last
         assign r_key   = '0;
         assign r_valid = 1'b0;
      end else begin : g_body
         assign r_key   = key_w[c+1];
         assign r_valid = valid_w[c+1];
      end

      phd_cell #(.KW(KW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .ins_key     (ins_key),
         .left_le     (l_le),
         .left_key    (l_key),
         .left_valid  (l_valid),
         .right_key   (r_key),
         .right_valid (r_valid),
         .key_o       (key_w[c]),
         .valid_o     (valid_w[c]),
         .le_o        (le_w[c])
      );
   end

   assign head_key = key_w[0];

endmodule
`default_nettype wire

[rtl/phd_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none
module phd_sqrt #(
   parameter int OPW = 49
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire logic [OPW-1:0] operand,
   output logic                done,
   output logic [(OPW+1)/2-1:0] root
);

   localparam int NW2  = OPW + (OPW % 2);
   localparam int RW   = NW2 / 2;
   localparam int REMW = RW + 3;
   localparam int CNTW = $clog2(RW + 1);

   logic [NW2-1:0]  opnd_ff, opnd_in;
   logic [REMW-1:0] rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            active_ff, active_in;
   logic            done_ff, done_in;
   logic [REMW-1:0] rem_sh, trial;

   assign rem_sh = {rem_ff[REMW-3:0], opnd_ff[NW2-1 -: 2]};
   assign trial  = REMW'({root_ff, 2'b01});

   always_comb begin
      opnd_in   = opnd_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      done_in   = 1'b0;
      if (start) begin
         opnd_in   = NW2'(operand);
         rem_in    = '0;
         root_in   = '0;
         cnt_in    = CNTW'(RW);
         active_in = 1'b1;
      end else if (active_ff) begin
         // one root bit per cycle
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         opnd_in = opnd_ff << 2;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff <= opnd_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

[rtl/partial_hausdorff_distance.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                   Handshake
// request   start, busy, req_data                   taken when start && !busy
// response  rsp_valid, rsp_data                     one-cycle strobe, no stall
// csr       csr_we, csr_index, csr_wdata            written when csr_we
//
// A load request does not raise busy. A compute request walks every point pair of
// both directions through one distance pipeline, one pair a cycle, feeding each
// row minimum into a chain of sorting cells, and for L2 runs a square root after
// the walk. busy stays high for the whole compute; a compute with an empty set
// answers in the next cycle without raising busy. Reset is synchronous and needs
// no sweep.
module partial_hausdorff_distance
   import phd_pkg::*;
#(
   parameter int MAX_POINTS = 256,
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [16:0] csr_wdata
);

`include "partial_hausdorff_distance_assert.svh"

   localparam int C    = COORD_BITS;
   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int KW   = 2 * C + 1;
   localparam int XW   = (C > 16) ? C : 16;
   localparam int NW   = KW + 2 * FRAC_BITS;
   localparam int RW   = (NW + 1) / 2;
   localparam int CMW  = (KW + FRAC_BITS > DIST_W) ? KW + FRAC_BITS : DIST_W;
   localparam int DRW  = $clog2(DRAIN_CYCLES);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN  = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_START = 3'd4;
   localparam logic [2:0] ST_ROOT  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic            dir_ff, dir_in;
   logic [CW-1:0]   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DRW-1:0]  drain_ff, drain_in;
   logic [KW-1:0]   best_ff, best_in;
   logic [CW-1:0]   count_a_ff, count_a_in, count_b_ff, count_b_in;
   logic            ovf_ff, ovf_in;
   logic            dist_type_ff;
   logic [16:0]     rank_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            wr_a, wr_b;
   logic [2*C-1:0]  wr_point;
   logic [2*C-1:0]  mem_a [MAX_POINTS];
   logic [2*C-1:0]  mem_b [MAX_POINTS];
   logic [2*C-1:0]  rd_a_ff, rd_b_ff;
   logic [AW-1:0]   addr_a, addr_b;
   logic [CW-1:0]   ns, nd, kns;
   logic [16:0]     rank_c;
   logic [17+CW-1:0] kprod;
   logic [CW-1:0]   k_calc;
   logic [XW-1:0]   xz, yz;

   pipe_tag_type    p0, p1_ff, p2_ff, p3_ff;
   logic [C-1:0]    ax_ff, ay_ff;
   logic [2*C-1:0]  tx_ff, ty_ff;
   logic            l2_p2_ff;
   logic [KW-1:0]   key3, cand, min_ff;
   logic            ins_valid_ff, ins_valid_in;
   logic [KW-1:0]   ins_key_ff;

   sort_ctl_type    sctl;
   logic            sort_clear, sort_shift;
   logic [KW-1:0]   head_key;
   logic            sqrt_start, sqrt_done;
   logic [RW-1:0]   sqrt_root;
   logic [CMW-1:0]  dist_wide;
   logic [DIST_W-1:0] dist_sat;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // coordinates: low COORD_BITS bits, sign carried by the top bit
   assign xz       = XW'($unsigned(req_data.x));
   assign yz       = XW'($unsigned(req_data.y));
   assign wr_point = {xz[C-1:0], yz[C-1:0]};
   assign wr_a = accept && (req_data.op == OP_LOAD_A) && (count_a_ff < CW'(MAX_POINTS));
   assign wr_b = accept && (req_data.op == OP_LOAD_B) && (count_b_ff < CW'(MAX_POINTS));

   assign ns     = dir_ff ? count_b_ff : count_a_ff;
   assign nd     = dir_ff ? count_a_ff : count_b_ff;
   assign addr_a = dir_ff ? j_ff[AW-1:0] : i_ff[AW-1:0];
   assign addr_b = dir_ff ? i_ff[AW-1:0] : j_ff[AW-1:0];

   assign kns    = (state_ff == ST_IDLE) ? count_a_ff : count_b_ff;
   assign rank_c = (rank_ff > RANK_ONE) ? RANK_ONE : rank_ff;
   assign kprod  = (17+CW)'(rank_c) * (17+CW)'(kns - 1'b1);
   assign k_calc = CW'(kprod >> 16);

   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[count_a_ff[AW-1:0]] <= wr_point;
      end
      rd_a_ff <= mem_a[addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[count_b_ff[AW-1:0]] <= wr_point;
      end
      rd_b_ff <= mem_b[addr_b];
   end

   // distance pipeline: read, absolute differences, square (L2 only), sum and row minimum
   logic [2*C-1:0]     src_pt, dst_pt;
   logic signed [C:0]  dx, dy;
   logic [C:0]         adx, ady;

   assign src_pt = dir_ff ? rd_b_ff : rd_a_ff;
   assign dst_pt = dir_ff ? rd_a_ff : rd_b_ff;
   assign dx  = $signed({src_pt[2*C-1], src_pt[2*C-1:C]})
              - $signed({dst_pt[2*C-1], dst_pt[2*C-1:C]});
   assign dy  = $signed({src_pt[C-1], src_pt[C-1:0]})
              - $signed({dst_pt[C-1], dst_pt[C-1:0]});
   assign adx = dx[C] ? (C+1)'(-dx) : (C+1)'(dx);
   assign ady = dy[C] ? (C+1)'(-dy) : (C+1)'(dy);

   assign key3 = KW'(tx_ff) + KW'(ty_ff);
   assign cand = (p3_ff.first || key3 < min_ff) ? key3 : min_ff;

   always_comb begin
      p0.valid = (state_ff == ST_SCAN);
      p0.first = (j_ff == '0);
      p0.last  = (j_ff == nd - 1'b1);
      ins_valid_in = p3_ff.valid && p3_ff.last;
   end

   always_ff @(posedge clock) begin
      ax_ff <= adx[C-1:0];
      ay_ff <= ady[C-1:0];
      l2_p2_ff <= (dist_type_ff == METRIC_L2);
      tx_ff <= l2_p2_ff ? (2*C)'(ax_ff) * (2*C)'(ax_ff) : (2*C)'(ax_ff);
      ty_ff <= l2_p2_ff ? (2*C)'(ay_ff) * (2*C)'(ay_ff) : (2*C)'(ay_ff);
      if (p3_ff.valid) begin
         min_ff <= cand;
      end
      ins_key_ff <= cand;
      if (reset) begin
         p1_ff        <= '0;
         p2_ff        <= '0;
         p3_ff        <= '0;
         ins_valid_ff <= 1'b0;
      end else begin
         p1_ff        <= p0;
         p2_ff        <= p1_ff;
         p3_ff        <= p2_ff;
         ins_valid_ff <= ins_valid_in;
      end
   end

   assign sctl.clear  = sort_clear;
   assign sctl.insert = ins_valid_ff;
   assign sctl.shift  = sort_shift;

   phd_sorter #(.N(MAX_POINTS), .KW(KW)) u_sorter (
      .clock    (clock),
      .reset    (reset),
      .ctl      (sctl),
      .ins_key  (ins_key_ff),
      .head_key (head_key)
   );

   phd_sqrt #(.OPW(NW)) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (NW'(best_ff) << (2 * FRAC_BITS)),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   assign dist_wide = (dist_type_ff == METRIC_L1) ? (CMW'(best_ff) << FRAC_BITS)
                                                  : CMW'(sqrt_root);
   assign dist_sat  = (dist_wide > CMW'(DIST_MAX)) ? DIST_MAX : dist_wide[DIST_W-1:0];

   always_comb begin
      state_in     = state_ff;
      dir_in       = dir_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      drain_in     = drain_ff;
      best_in      = best_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      sort_clear   = 1'b0;
      sort_shift   = 1'b0;
      sqrt_start   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_data.op)
                  OP_LOAD_A: begin
                     if (wr_a) count_a_in = count_a_ff + 1'b1;
                     else ovf_in = 1'b1;
                  end
                  OP_LOAD_B: begin
                     if (wr_b) count_b_in = count_b_ff + 1'b1;
                     else ovf_in = 1'b1;
                  end
                  OP_COMPUTE: begin
                     if (count_a_ff == '0 || count_b_ff == '0) begin
                        rsp_valid_in         = 1'b1;
                        rsp_data_in.distance = '0;
                        rsp_data_in.status   = STATUS_EMPTY;
                        count_a_in = '0;
                        count_b_in = '0;
                        ovf_in     = 1'b0;
                     end else begin
                        dir_in     = 1'b0;
                        i_in       = '0;
                        j_in       = '0;
                        k_in       = k_calc;
                        sort_clear = 1'b1;
                        state_in   = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (j_ff == nd - 1'b1) begin
               j_in = '0;
               if (i_ff == ns - 1'b1) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            // let the last row minimum reach the sorter
            drain_in = drain_ff + 1'b1;
            if (drain_ff == DRW'(DRAIN_CYCLES - 1)) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (k_ff != '0) begin
               sort_shift = 1'b1;
               k_in       = k_ff - 1'b1;
            end else if (!dir_ff) begin
               best_in    = head_key;
               dir_in     = 1'b1;
               i_in       = '0;
               j_in       = '0;
               k_in       = k_calc;
               sort_clear = 1'b1;
               state_in   = ST_SCAN;
            end else begin
               best_in  = (head_key > best_ff) ? head_key : best_ff;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (dist_type_ff == METRIC_L1) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.distance = dist_sat;
               rsp_data_in.status   = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               count_a_in = '0;
               count_b_in = '0;
               ovf_in     = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.distance = dist_sat;
               rsp_data_in.status   = ovf_ff ? STATUS_OVERFLOW : STATUS_OK;
               count_a_in = '0;
               count_b_in = '0;
               ovf_in     = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      drain_ff    <= drain_in;
      best_ff     <= best_in;
      dir_ff      <= dir_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dist_type_ff <= METRIC_L2;
         rank_ff      <= RANK_ONE;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == CSR_DIST_TYPE) dist_type_ff <= csr_wdata[0];
         if (csr_we && csr_index == CSR_RANK_Q16) rank_ff <= csr_wdata;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PHD_ASSERT_IMPLY(a_scan_sets_loaded, clock, reset, state_ff == ST_SCAN,
      count_a_ff != '0 && count_b_ff != '0, "scan with an empty set")
   `PHD_ASSERT_IMPLY(a_insert_in_walk, clock, reset, ins_valid_ff,
      state_ff == ST_SCAN || state_ff == ST_DRAIN, "row minimum outside the walk")
   `PHD_ASSERT_NEXT(a_compute_counts_cleared, clock, reset, rsp_valid_in,
      count_a_ff == '0 && count_b_ff == '0 && !ovf_ff, "sets not cleared after compute")

endmodule
`default_nettype wire
